/* rtl/lsf_pkg.sv */
package lsf_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int WIN_IDX_W   = $clog2(PATTERN_MAX);
  localparam int LINE_MAX    = 1023;
  localparam int LINE_W      = 10;
  localparam int PLEN_W      = 5;
  localparam int PREFIX_W    = 4;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_LENGTH  = CFG_INDEX_W'(3);

  typedef struct packed {
    logic [PLEN_W-1:0]       pattern_length;
    logic [2*CFG_DATA_W-1:0] pattern;
    logic [PREFIX_W-1:0]     prefix_length;
  } cfg_t;

  typedef struct packed {
    logic step;
    logic is_nl;
    logic last;
    logic line_end;
  } step_t;

  typedef struct packed {
    logic [15:0]       line_number;
    logic [31:0]       line_offset;
    logic [LINE_W-1:0] line_bytes;
  } result_t;

endpackage

/* rtl/lsf_if.sv */
interface lsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_in_buffer;
  modport source(output valid, char_byte, last_in_buffer, input ready);
  modport sink(input valid, char_byte, last_in_buffer, output ready);
endinterface

interface lsf_out_if import lsf_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [15:0]       line_number;
  logic [31:0]       line_offset;
  logic [LINE_W-1:0] line_bytes;
  modport source(output valid, line_number, line_offset, line_bytes, input ready);
  modport sink(input valid, line_number, line_offset, line_bytes, output ready);
endinterface

interface lsf_cfg_if import lsf_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/lsf_match.sv */
module lsf_match import lsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  step_t             ctl,
  input  logic [7:0]        char_byte,
  input  cfg_t              cfg,
  input  logic [LINE_W-1:0] count,
  output logic              hit
);

  logic [7:0]          window [PATTERN_MAX];
  logic [7:0]          win_shift [PATTERN_MAX];
  logic [PLEN_W-1:0]   plen;
  logic [PLEN_W-1:0]   idx [PATTERN_MAX];
  logic [LINE_W-1:0]   threshold;
  logic                mismatch;

  always_comb begin
    plen = cfg.pattern_length;
    if (plen == '0) begin
      plen = PLEN_W'(1);
    end else if (plen > PLEN_W'(PATTERN_MAX)) begin
      plen = PLEN_W'(PATTERN_MAX);
    end
  end

  always_comb begin
    win_shift[0] = char_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_shift[i] = window[i-1];
    end
  end

  // pattern byte k lines up with window slot plen-1-k
  always_comb begin
    mismatch = 1'b0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      idx[k] = plen - PLEN_W'(1) - PLEN_W'(k);
      if ((PLEN_W'(k) < plen) &&
          (win_shift[idx[k][WIN_IDX_W-1:0]] != cfg.pattern[8*k +: 8])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign threshold = LINE_W'(cfg.prefix_length) + LINE_W'(plen);
  assign hit = !ctl.is_nl && !mismatch && (count >= threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        window[i] <= '0;
      end
    end else if (ctl.step) begin
      if (ctl.line_end) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
          window[i] <= '0;
        end
      end else if (!ctl.is_nl) begin
        window <= win_shift;
      end
    end
  end

endmodule

/* rtl/lsf_line.sv */
module lsf_line import lsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  step_t             ctl,
  input  logic              hit,
  output logic [LINE_W-1:0] count,
  output logic              emit,
  output result_t           result
);

  logic [LINE_W-1:0] position;
  logic              has_match;
  logic [15:0]       line_counter;
  logic [31:0]       buffer_offset;
  logic [31:0]       line_origin;

  // line length saturates
  assign count = (position < LINE_W'(LINE_MAX)) ? position + LINE_W'(1)
                                                 : LINE_W'(LINE_MAX);

  assign emit = ctl.line_end && (has_match || hit);
  assign result.line_number = line_counter;
  assign result.line_offset = line_origin;
  assign result.line_bytes  = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      has_match     <= 1'b0;
      line_counter  <= '0;
      buffer_offset <= '0;
      line_origin   <= '0;
    end else if (ctl.step) begin
      if (ctl.line_end) begin
        position  <= '0;
        has_match <= 1'b0;
        if (ctl.last) begin
          line_counter  <= '0;
          buffer_offset <= '0;
          line_origin   <= '0;
        end else begin
          line_counter  <= line_counter + 16'd1;
          buffer_offset <= buffer_offset + 32'd1;
          line_origin   <= buffer_offset + 32'd1;
        end
      end else begin
        position      <= count;
        buffer_offset <= buffer_offset + 32'd1;
        if (hit) begin
          has_match <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/line_substring_filter.sv */
// Line filter: bytes of a text buffer stream in on text, one transfer per
// clock, and a line that holds the configured pattern (not starting inside
// its prefix, never crossing a newline) yields one transfer on hits when its
// newline or the final buffer byte arrives. Throughput is one byte per cycle;
// a result is offered on hits from the result register, after the byte that
// ends its line has passed the input register and the combinational window
// compare. While a result waits on hits, the input stalls. Configuration
// writes are taken at any time and should only be made while the block is
// idle.
module line_substring_filter import lsf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lsf_in_if.sink    text,
  lsf_out_if.source hits,
  lsf_cfg_if.sink   cfg
);

  cfg_t              cfg_regs;
  logic              s1_valid;
  logic [7:0]        s1_char;
  logic              s1_last;
  logic              s1_adv;
  step_t             ctl;
  logic              hit;
  logic [LINE_W-1:0] count;
  logic              emit;
  result_t           result;
  logic              out_valid;
  result_t           out_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.pattern_length <= PLEN_W'(1);
      cfg_regs.pattern        <= '0;
      cfg_regs.prefix_length  <= PREFIX_W'(4);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PATTERN_LENGTH: cfg_regs.pattern_length <= cfg.data[PLEN_W-1:0];
        REG_PATTERN_LOW:    cfg_regs.pattern[CFG_DATA_W-1:0] <= cfg.data;
        REG_PATTERN_HIGH:   cfg_regs.pattern[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg.data;
        REG_PREFIX_LENGTH:  cfg_regs.prefix_length <= cfg.data[PREFIX_W-1:0];
        default: ;
      endcase
    end
  end

  // input register moves on whenever the result register can take its outcome
  assign s1_adv     = s1_valid && (!out_valid || hits.ready);
  assign text.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_char <= text.char_byte;
      s1_last <= text.last_in_buffer;
    end
  end

  always_comb begin
    ctl.step     = s1_adv;
    ctl.is_nl    = (s1_char == NEWLINE_BYTE);
    ctl.last     = s1_last;
    ctl.line_end = ctl.is_nl || s1_last;
  end

  lsf_match u_match (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .char_byte (s1_char),
    .cfg       (cfg_regs),
    .count     (count),
    .hit       (hit)
  );

  lsf_line u_line (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .hit    (hit),
    .count  (count),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= emit;
    end else if (hits.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_data <= result;
    end
  end

  assign hits.valid       = out_valid;
  assign hits.line_number = out_data.line_number;
  assign hits.line_offset = out_data.line_offset;
  assign hits.line_bytes  = out_data.line_bytes;

endmodule

/* tb/sv/tb_line_substring_filter.sv */
module tb_line_substring_filter import lsf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time CLK_PERIOD   = 2ns;
  localparam int  RESET_CYCLES = 7;
  localparam int  DRAIN_CYCLES = 10;
  localparam int  LONG_HOLD    = 300;
  localparam int  CYCLE_LIMIT  = 1_500_000;
  localparam int  REPORT_LIMIT = 100;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lsf_in_if  text_if();
  lsf_out_if hits_if();
  lsf_cfg_if cfg_if();

  line_substring_filter u_top (
    .clk  (clk),
    .rst  (rst),
    .text (text_if),
    .hits (hits_if),
    .cfg  (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // filter state as the block should hold it
  logic [7:0]          win [PATTERN_MAX] = '{default: 8'h00};
  int                  line_pos    = 0;
  bit                  line_hit    = 1'b0;
  logic [15:0]         line_idx    = '0;
  logic [31:0]         byte_off    = '0;
  logic [31:0]         line_origin = '0;
  logic [PLEN_W-1:0]   m_plen      = PLEN_W'(1);
  logic [63:0]         m_pat_lo    = '0;
  logic [63:0]         m_pat_hi    = '0;
  logic [PREFIX_W-1:0] m_prefix    = PREFIX_W'(4);

  text_item_t text_pending [$];
  result_t    hit_expected [$];
  result_t    hit_want;
  text_item_t text_next;

  int mismatch_count  = 0;
  int cycle_count     = 0;
  int src_gap_left    = 0;
  int sink_stall_left = 0;
  int hold_left       = 0;
  int holds_requested = 0;
  int holds_granted   = 0;
  bit src_gaps_on     = 1'b1;
  bit sink_stalls_on  = 1'b1;

  logic [7:0] filler_a = 8'h61;
  logic [7:0] filler_b = 8'h62;

  function automatic logic [7:0] pattern_at(int k);
    if (k < 8) return m_pat_lo[8*k +: 8];
    return m_pat_hi[8*(k-8) +: 8];
  endfunction

  function automatic int pattern_span();
    if (m_plen == 0) return 1;
    if (m_plen > PATTERN_MAX) return PATTERN_MAX;
    return int'(m_plen);
  endfunction

  function automatic void scan_text_byte(logic [7:0] c, logic last);
    int      count;
    int      span;
    bit      hit;
    result_t r;
    count = (line_pos < LINE_MAX) ? line_pos + 1 : LINE_MAX;
    if (c != NEWLINE_BYTE) begin
      span = pattern_span();
      for (int k = PATTERN_MAX - 1; k > 0; k--) win[k] = win[k-1];
      win[0] = c;
      // match must start at or after the prefix
      if (count >= int'(m_prefix) + span) begin
        hit = 1'b1;
        for (int k = 0; k < span; k++)
          if (win[span-1-k] != pattern_at(k)) hit = 1'b0;
        if (hit) line_hit = 1'b1;
      end
    end
    line_pos = count;
    if (c == NEWLINE_BYTE || last) begin
      if (line_hit) begin
        r.line_number = line_idx;
        r.line_offset = line_origin;
        r.line_bytes  = LINE_W'(count);
        hit_expected.push_back(r);
      end
      line_idx++;
      byte_off++;
      line_origin = byte_off;
      line_pos    = 0;
      line_hit    = 1'b0;
      for (int k = 0; k < PATTERN_MAX; k++) win[k] = 8'h00;
      if (last) begin
        line_idx    = '0;
        byte_off    = '0;
        line_origin = '0;
      end
    end else begin
      byte_off++;
    end
  endfunction

  function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      text_if.valid <= 1'b0;
      src_gap_left = 0;
    end else begin
      if (text_if.valid && text_if.ready)
        scan_text_byte(text_if.char_byte, text_if.last_in_buffer);
      if (!text_if.valid || text_if.ready) begin
        if (src_gap_left > 0) begin
          src_gap_left--;
          text_if.valid <= 1'b0;
        end else if (text_pending.size() != 0) begin
          text_next = text_pending.pop_front();
          text_if.valid          <= 1'b1;
          text_if.char_byte      <= text_next.ch;
          text_if.last_in_buffer <= text_next.last;
          src_gap_left = !src_gaps_on ? 0 :
                         ($urandom_range(0, 19) < 13) ? 0 :
                         ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) :
                         $urandom_range(1, 3);
        end else begin
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      hits_if.ready <= 1'b0;
      sink_stall_left = 0;
    end else begin
      if (hits_if.valid && hits_if.ready) begin
        if (hit_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result expected none actual line %0d offset %0d bytes %0d",
                     $time, hits_if.line_number, hits_if.line_offset, hits_if.line_bytes);
        end else begin
          hit_want = hit_expected.pop_front();
          if (hits_if.line_number !== hit_want.line_number)
            note_mismatch("line_number", 32'(hit_want.line_number), 32'(hits_if.line_number));
          if (hits_if.line_offset !== hit_want.line_offset)
            note_mismatch("line_offset", hit_want.line_offset, hits_if.line_offset);
          if (hits_if.line_bytes !== hit_want.line_bytes)
            note_mismatch("line_bytes", 32'(hit_want.line_bytes), 32'(hits_if.line_bytes));
        end
      end
      if (sink_stall_left > 0)
        sink_stall_left--;
      else if (sink_stalls_on && $urandom_range(0, 99) < 20)
        sink_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                          $urandom_range(1, 2);
      hits_if.ready <= (hold_left == 0) && (sink_stall_left == 0);
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_granted != holds_requested) begin
      hold_left     <= LONG_HOLD;
      holds_granted <= holds_granted + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] c, input logic last);
    text_item_t t;
    t.ch   = c;
    t.last = last;
    text_pending.push_back(t);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return pattern_at($urandom_range(0, pattern_span() - 1));
    if (r < 65) return filler_a;
    if (r < 75) return filler_b;
    if (r < 78) return NEWLINE_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // a line with the pattern planted somewhere (or not), sometimes cut short
  task automatic add_random_line();
    int         len;
    int         plant_at;
    int         span;
    int         r;
    logic [7:0] c;
    span = pattern_span();
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) :
          $urandom_range(int'(m_prefix), int'(m_prefix) + span + 12);
    r = $urandom_range(0, 9);
    if (r < 3)      plant_at = -1;
    else if (r < 5) plant_at = int'(m_prefix) - int'($urandom_range(0, 1));
    else            plant_at = $urandom_range(0, len);
    for (int i = 0; i < len; i++) begin
      c = (plant_at >= 0 && i >= plant_at && i < plant_at + span) ?
          pattern_at(i - plant_at) : pick_char();
      add_byte(c, 1'b0);
    end
    r = $urandom_range(0, 19);
    if (r == 0) add_byte(pick_char(), 1'b1);
    else        add_byte(NEWLINE_BYTE, r == 1);
  endtask

  task automatic add_long_line(input int len, input int plant_at, input logic last);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      if (i >= plant_at && i < plant_at + pattern_span()) c = pattern_at(i - plant_at);
      else c = $urandom_range(0, 1) ? filler_a : filler_b;
      add_byte(c, 1'b0);
    end
    add_byte(NEWLINE_BYTE, last);
  endtask

  task automatic set_filter(input logic [PLEN_W-1:0] plen, input logic [63:0] lo,
                            input logic [63:0] hi, input logic [PREFIX_W-1:0] prefix);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0]  val [4];
    idx = '{REG_PATTERN_LENGTH, REG_PATTERN_LOW, REG_PATTERN_HIGH, REG_PREFIX_LENGTH};
    val = '{CFG_DATA_W'(plen), lo, hi, CFG_DATA_W'(prefix)};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      do @(posedge clk); while (!cfg_if.ready);
      cfg_if.valid <= 1'b0;
      case (idx[i])
        REG_PATTERN_LENGTH: m_plen   = val[i][PLEN_W-1:0];
        REG_PATTERN_LOW:    m_pat_lo = val[i];
        REG_PATTERN_HIGH:   m_pat_hi = val[i];
        REG_PREFIX_LENGTH:  m_prefix = val[i][PREFIX_W-1:0];
        default: ;
      endcase
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (text_pending.size() != 0 || text_if.valid || hit_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int                  r;
    int                  phase_end;
    logic [127:0]        pat;
    logic [PLEN_W-1:0]   plen;
    logic [PREFIX_W-1:0] prefix;

    text_if.valid          = 1'b0;
    text_if.char_byte      = 8'h00;
    text_if.last_in_buffer = 1'b0;
    hits_if.ready          = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = '0;
    cfg_if.data            = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: single zero byte pattern, prefix of four
    add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0); add_byte(NEWLINE_BYTE, 1'b0);
    repeat (4) add_byte(8'h41, 1'b0);
    add_byte(8'h00, 1'b0); add_byte(NEWLINE_BYTE, 1'b0);
    wait_drained();

    // zero length acts as one; final byte without newline; empty last line
    set_filter('0, '1, '1, '0);
    add_byte(8'hFF, 1'b1);
    add_byte(NEWLINE_BYTE, 1'b1);
    add_byte(8'hFF, 1'b0); add_byte(NEWLINE_BYTE, 1'b0);
    wait_drained();

    // oversized length clamps to the full sixteen bytes
    set_filter(PLEN_W'(31), 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, '0);
    for (int k = 0; k < PATTERN_MAX; k++) add_byte(pattern_at(k), 1'b0);
    add_byte(NEWLINE_BYTE, 1'b0);
    wait_drained();

    // every line matches while the receiver holds off
    set_filter(PLEN_W'(1), 64'h78, '0, '0);
    src_gaps_on = 1'b0;
    @(posedge clk);
    holds_requested <= holds_requested + 1;
    @(negedge clk);
    repeat (60) begin
      add_byte(8'h78, 1'b0);
      add_byte(NEWLINE_BYTE, 1'b0);
    end
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      r = $urandom_range(0, 9);
      plen = (r == 0) ? PLEN_W'(0) : (r == 1) ? PLEN_W'(31) : (r == 2) ? PLEN_W'(16) :
             PLEN_W'($urandom_range(1, 6));
      if ($urandom_range(0, 3) == 0)
        prefix = $urandom_range(0, 1) ? PREFIX_W'(15) : PREFIX_W'(0);
      else
        prefix = PREFIX_W'($urandom_range(0, 8));
      for (int k = 0; k < 16; k++)
        pat[8*k +: 8] = ($urandom_range(0, 19) == 0) ? NEWLINE_BYTE :
                        8'($urandom_range(0, 255));
      set_filter(plen, pat[63:0], pat[127:64], prefix);
      filler_a       = 8'($urandom_range(0, 255));
      filler_b       = 8'($urandom_range(0, 255));
      src_gaps_on    = $urandom_range(0, 3) != 0;
      sink_stalls_on = $urandom_range(0, 3) != 0;
      phase_end = text_pending.size() + 25;
      while (text_pending.size() < phase_end) begin
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 20))
            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 49) == 0);
        else
          add_random_line();
      end
      wait_drained();
    end

    // long line: length saturates, window keeps working past the limit
    set_filter(PLEN_W'(3), 64'h0063_6261, '0, PREFIX_W'(15));
    filler_a       = 8'h7A;
    filler_b       = 8'h79;
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b1;
    add_long_line(1026, 1022, 1'b1);
    wait_drained();

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
rtl/lsf_pkg.sv
rtl/lsf_if.sv
rtl/lsf_match.sv
rtl/lsf_line.sv
rtl/line_substring_filter.sv
tb/sv/tb_line_substring_filter.sv
